### rtl/core/gmer_pkg.sv
// Shared constants, types and helpers for the greedy mesh edge router.
// Used by gmer_port_table and greedy_mesh_edge_router; depends on nothing else.
`timescale 1ns / 1ps

package gmer_pkg;

    localparam int GRID_SIDE   = 8;
    localparam int SIDE_W      = 4;
    localparam int COORD_W     = 3;
    localparam int CELL_W      = 6;
    localparam int NODE_W      = 6;
    localparam int DIR_W       = 2;
    localparam int PORT_ADDR_W = CELL_W + DIR_W;
    localparam int PORT_DEPTH  = 1 << PORT_ADDR_W;
    localparam int CELL_COUNT  = 1 << CELL_W;

    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

    // Requests from the walk sequencer to the port owner table.
    typedef struct packed {
        logic                   clear;
        logic                   wr_en;
        logic [PORT_ADDR_W-1:0] wr_addr;
        logic [NODE_W-1:0]      wr_owner;
        logic [PORT_ADDR_W-1:0] rd_a_addr;
        logic [PORT_ADDR_W-1:0] rd_b_addr;
    } port_req_t;

    // Registered read data from the port owner table.
    typedef struct packed {
        logic              a_taken;
        logic [NODE_W-1:0] a_owner;
        logic              b_taken;
        logic [NODE_W-1:0] b_owner;
    } port_rsp_t;

    // Move order within one pass: right, left, down, up.
    function automatic logic [DIR_W-1:0] try_dir(input logic [1:0] slot);
        logic [DIR_W-1:0] d;
        case (slot)
            2'd0:    d = DIR_RIGHT;
            2'd1:    d = DIR_LEFT;
            2'd2:    d = DIR_DOWN;
            default: d = DIR_UP;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/gmer_port_table.sv
// Port owner table: one owner per outgoing port of every mesh cell.
// Depends on gmer_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module gmer_port_table
    import gmer_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  port_req_t req,
    output port_rsp_t rsp
);

    // Owner values live in a plain memory; a set taken bit marks a claimed port.
    logic [NODE_W-1:0]     owner_mem [PORT_DEPTH];
    logic [PORT_DEPTH-1:0] taken_reg;
    logic [PORT_DEPTH-1:0] taken_next;
    port_rsp_t             rsp_reg;

    always_comb begin
        taken_next = taken_reg;
        if (req.clear) begin
            taken_next = '0;
        end else if (req.wr_en) begin
            taken_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg <= '0;
        end else begin
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            owner_mem[req.wr_addr] <= req.wr_owner;
        end
        rsp_reg.a_owner <= owner_mem[req.rd_a_addr];
        rsp_reg.b_owner <= owner_mem[req.rd_b_addr];
        rsp_reg.a_taken <= taken_reg[req.rd_a_addr];
        rsp_reg.b_taken <= taken_reg[req.rd_b_addr];
    end

    assign rsp = rsp_reg;

endmodule

### rtl/core/greedy_mesh_edge_router.sv
// Greedy mesh edge router top level: input unpacking, walk sequencer, output register.
// Depends on gmer_pkg and gmer_port_table.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata: one edge to route
// m_        out        m_tvalid/m_tready  m_tdata: path cell, m_tuser: flags, m_tlast
// cfg_      in         cfg_we             cfg_wdata: mesh side in use
//
// An edge is walked one hop at a time. Each hop tries moves in slot order: a move that
// is actually tested reads the two port owners, then checks them; a move that is out
// of the mesh or, in the first pass, not toward the target is passed over. The hop then
// hands the cell to the output register. The registered port table read sets the pace.
// Skipped, trivial and out-of-range edges go straight to the output register.
// Reset is synchronous on aresetn low: all ports free, no failure, side 8.
// The input is not ready while an edge is walking; a stalled output holds the walk
// before the next hop, and the last result may still wait while a new edge is taken.

module greedy_mesh_edge_router
    import gmer_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration: mesh side in use.
    input  logic              cfg_we,
    input  logic [SIDE_W-1:0] cfg_wdata,
    // Edge input.
    input  logic              s_tvalid,
    output logic              s_tready,
    // Bits from low: start_run[0], src_node[6:1], src_row[9:7], src_col[12:10],
    // dst_row[15:13], dst_col[18:16], zero fill [23:19].
    input  logic [23:0]       s_tdata,
    // Path cell output.
    output logic              m_tvalid,
    input  logic              m_tready,
    // Bits from low: cell_res[5:0], zero fill [7:6].
    output logic [7:0]        m_tdata,
    // Bits from low: cell_valid[0], routed_ok[1].
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;

    // Unpacked input fields.
    logic               in_start;
    logic [NODE_W-1:0]  in_node;
    logic [COORD_W-1:0] in_srow, in_scol, in_drow, in_dcol;

    assign in_start = s_tdata[0];
    assign in_node  = s_tdata[6:1];
    assign in_srow  = s_tdata[9:7];
    assign in_scol  = s_tdata[12:10];
    assign in_drow  = s_tdata[15:13];
    assign in_dcol  = s_tdata[18:16];

    logic [2:0]          state_reg, state_next;
    logic [SIDE_W-1:0]   grid_side_reg, grid_side_next;
    logic                run_failed_reg, run_failed_next;
    logic [NODE_W-1:0]   owner_reg, owner_next;
    logic [COORD_W-1:0]  dst_row_reg, dst_row_next, dst_col_reg, dst_col_next;
    logic [COORD_W-1:0]  walk_row_reg, walk_row_next, walk_col_reg, walk_col_next;
    logic [COORD_W-1:0]  nb_row_reg, nb_row_next, nb_col_reg, nb_col_next;
    logic [CELL_W-1:0]   cur_cell_reg, cur_cell_next, nb_cell_reg, nb_cell_next;
    logic [DIR_W-1:0]    dir_reg, dir_next;
    logic [2:0]          try_reg, try_next;
    logic [CELL_COUNT-1:0] visited_reg, visited_next;

    // Result waiting to go into the output register.
    logic [CELL_W-1:0]   pend_cell_reg, pend_cell_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_last_reg, pend_last_next;
    logic                pend_ok_reg, pend_ok_next;

    // Output register.
    logic                m_tvalid_reg, m_tvalid_next;
    logic [CELL_W-1:0]   m_cell_reg, m_cell_next;
    logic                m_cellv_reg, m_cellv_next;
    logic                m_last_reg, m_last_next;
    logic                m_ok_reg, m_ok_next;

    // Effective side, clamped into the supported range.
    logic [SIDE_W-1:0] side_eff;
    always_comb begin
        if (grid_side_reg < SIDE_W'(2)) begin
            side_eff = SIDE_W'(2);
        end else if (grid_side_reg > SIDE_W'(GRID_SIDE)) begin
            side_eff = SIDE_W'(GRID_SIDE);
        end else begin
            side_eff = grid_side_reg;
        end
    end

    // Candidate move for the current try slot.
    logic [DIR_W-1:0]   cand_dir;
    logic               bound_ok, toward, applicable;
    logic [COORD_W-1:0] cand_row, cand_col;

    always_comb begin
        cand_dir = try_dir(try_reg[1:0]);
        cand_row = walk_row_reg;
        cand_col = walk_col_reg;
        bound_ok = 1'b0;
        toward   = 1'b0;
        case (cand_dir)
            DIR_UP: begin
                bound_ok = (walk_row_reg != '0);
                toward   = (dst_row_reg < walk_row_reg);
                cand_row = walk_row_reg - COORD_W'(1);
            end
            DIR_RIGHT: begin
                bound_ok = ({1'b0, walk_col_reg} + SIDE_W'(1)) < side_eff;
                toward   = (dst_col_reg > walk_col_reg);
                cand_col = walk_col_reg + COORD_W'(1);
            end
            DIR_DOWN: begin
                bound_ok = ({1'b0, walk_row_reg} + SIDE_W'(1)) < side_eff;
                toward   = (dst_row_reg > walk_row_reg);
                cand_row = walk_row_reg + COORD_W'(1);
            end
            default: begin
                bound_ok = (walk_col_reg != '0);
                toward   = (dst_col_reg < walk_col_reg);
                cand_col = walk_col_reg - COORD_W'(1);
            end
        endcase
        // The second pass (upper try slots) drops the direction condition.
        applicable = bound_ok && (try_reg[2] || toward);
    end

    // The one multiplier: row * side + col. While idle it indexes the source
    // cell of the arriving edge, otherwise the candidate neighbor.
    logic [COORD_W-1:0]        mul_row, mul_col;
    logic [COORD_W+SIDE_W-1:0] mul_prod;
    logic [CELL_W-1:0]         cell_idx;

    assign mul_row  = (state_reg == ST_IDLE) ? in_srow : cand_row;
    assign mul_col  = (state_reg == ST_IDLE) ? in_scol : cand_col;
    assign mul_prod = (COORD_W+SIDE_W)'(mul_row) * (COORD_W+SIDE_W)'(side_eff);
    assign cell_idx = mul_prod[CELL_W-1:0] + CELL_W'(mul_col);

    // Port owner table.
    port_req_t port_req;
    port_rsp_t port_rsp;
    logic      accept;
    logic      move_ok;
    logic      arrive;
    logic      out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign move_ok = (!port_rsp.a_taken || (port_rsp.a_owner == owner_reg))
                  && !(port_rsp.b_taken && (port_rsp.b_owner == owner_reg))
                  && !visited_reg[nb_cell_reg];
    assign arrive  = (nb_row_reg == dst_row_reg) && (nb_col_reg == dst_col_reg);

    always_comb begin
        port_req.clear     = accept && in_start;
        port_req.wr_en     = (state_reg == ST_CHECK) && move_ok;
        port_req.wr_addr   = {cur_cell_reg, dir_reg};
        port_req.wr_owner  = owner_reg;
        port_req.rd_a_addr = {cur_cell_reg, cand_dir};
        port_req.rd_b_addr = {cell_idx, cand_dir ^ DIR_DOWN};
    end

    gmer_port_table u_port_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (port_req),
        .rsp     (port_rsp)
    );

    // Walk sequencer.
    logic fail_eff;
    logic range_bad;

    always_comb begin
        fail_eff  = in_start ? 1'b0 : run_failed_reg;
        range_bad = ({1'b0, in_srow} >= side_eff) || ({1'b0, in_scol} >= side_eff)
                 || ({1'b0, in_drow} >= side_eff) || ({1'b0, in_dcol} >= side_eff);
    end

    always_comb begin
        state_next      = state_reg;
        grid_side_next  = cfg_we ? cfg_wdata : grid_side_reg;
        run_failed_next = run_failed_reg;
        owner_next      = owner_reg;
        dst_row_next    = dst_row_reg;
        dst_col_next    = dst_col_reg;
        walk_row_next   = walk_row_reg;
        walk_col_next   = walk_col_reg;
        nb_row_next     = nb_row_reg;
        nb_col_next     = nb_col_reg;
        cur_cell_next   = cur_cell_reg;
        nb_cell_next    = nb_cell_reg;
        dir_next        = dir_reg;
        try_next        = try_reg;
        visited_next    = visited_reg;
        pend_cell_next  = pend_cell_reg;
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        pend_ok_next    = pend_ok_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_cell_next     = m_cell_reg;
        m_cellv_next    = m_cellv_reg;
        m_last_next     = m_last_reg;
        m_ok_next       = m_ok_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    owner_next      = in_node;
                    dst_row_next    = in_drow;
                    dst_col_next    = in_dcol;
                    visited_next    = '0;
                    run_failed_next = fail_eff || range_bad;
                    pend_cell_next  = '0;
                    pend_valid_next = 1'b0;
                    pend_last_next  = 1'b1;
                    if (fail_eff || range_bad) begin
                        // Skipped or out-of-mesh edge: a single empty failing item.
                        pend_ok_next = 1'b0;
                        state_next   = ST_EMIT;
                    end else if ((in_srow == in_drow) && (in_scol == in_dcol)) begin
                        // Source already at the destination: nothing to walk.
                        pend_ok_next = 1'b1;
                        state_next   = ST_EMIT;
                    end else begin
                        walk_row_next = in_srow;
                        walk_col_next = in_scol;
                        cur_cell_next = cell_idx;
                        try_next      = '0;
                        state_next    = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                // Port reads go out this cycle; their data is checked next cycle.
                dir_next     = cand_dir;
                nb_row_next  = cand_row;
                nb_col_next  = cand_col;
                nb_cell_next = cell_idx;
                if (applicable) begin
                    state_next = ST_CHECK;
                end else if (try_reg == 3'd7) begin
                    run_failed_next = 1'b1;
                    pend_cell_next  = cur_cell_reg;
                    pend_valid_next = 1'b1;
                    pend_last_next  = 1'b1;
                    pend_ok_next    = 1'b0;
                    state_next      = ST_EMIT;
                end else begin
                    try_next = try_reg + 3'd1;
                end
            end
            ST_CHECK: begin
                if (move_ok) begin
                    visited_next[cur_cell_reg] = 1'b1;
                    walk_row_next   = nb_row_reg;
                    walk_col_next   = nb_col_reg;
                    cur_cell_next   = nb_cell_reg;
                    pend_cell_next  = cur_cell_reg;
                    pend_valid_next = 1'b1;
                    pend_last_next  = arrive;
                    pend_ok_next    = arrive;
                    state_next      = ST_EMIT;
                end else if (try_reg == 3'd7) begin
                    // Dead end: the current cell closes the edge as a failure.
                    run_failed_next = 1'b1;
                    pend_cell_next  = cur_cell_reg;
                    pend_valid_next = 1'b1;
                    pend_last_next  = 1'b1;
                    pend_ok_next    = 1'b0;
                    state_next      = ST_EMIT;
                end else begin
                    try_next   = try_reg + 3'd1;
                    state_next = ST_ISSUE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_cell_next   = pend_cell_reg;
                    m_cellv_next  = pend_valid_reg;
                    m_last_next   = pend_last_reg;
                    m_ok_next     = pend_ok_reg;
                    try_next      = '0;
                    state_next    = pend_last_reg ? ST_IDLE : ST_ISSUE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            grid_side_reg  <= SIDE_W'(GRID_SIDE);
            run_failed_reg <= 1'b0;
            visited_reg    <= '0;
            try_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            walk_row_reg   <= '0;
            walk_col_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            grid_side_reg  <= grid_side_next;
            run_failed_reg <= run_failed_next;
            visited_reg    <= visited_next;
            try_reg        <= try_next;
            m_tvalid_reg   <= m_tvalid_next;
            walk_row_reg   <= walk_row_next;
            walk_col_reg   <= walk_col_next;
        end
    end

    always_ff @(posedge aclk) begin
        owner_reg      <= owner_next;
        dst_row_reg    <= dst_row_next;
        dst_col_reg    <= dst_col_next;
        nb_row_reg     <= nb_row_next;
        nb_col_reg     <= nb_col_next;
        cur_cell_reg   <= cur_cell_next;
        nb_cell_reg    <= nb_cell_next;
        dir_reg        <= dir_next;
        pend_cell_reg  <= pend_cell_next;
        pend_valid_reg <= pend_valid_next;
        pend_last_reg  <= pend_last_next;
        pend_ok_reg    <= pend_ok_next;
        m_cell_reg     <= m_cell_next;
        m_cellv_reg    <= m_cellv_next;
        m_last_reg     <= m_last_next;
        m_ok_reg       <= m_ok_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_cell_reg};
    assign m_tuser  = {m_ok_reg, m_cellv_reg};
    assign m_tlast  = m_last_reg;

endmodule
